>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ICD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ICD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/icd_pkg.sv
// Package for the ideal beta-carbon deviation block: widths, coefficients, payload types.
// Depends on nothing.
package icd_pkg;
  localparam int CoordW = 24;
  localparam int DiffW = 25;
  localparam int CrossW = 51;
  localparam int XrW = 41;
  localparam int SumW = 64;
  localparam int DevW = 45;
  localparam int SqW = 50;
  localparam int LenW = 25;
  localparam int SqrtSteps = 25;
  localparam logic signed [20:0] CoefCross = 21'sd611041;
  localparam logic signed [20:0] CoefN = 21'sd595621;
  localparam logic signed [20:0] CoefC = 21'sd566938;

  typedef struct packed {
    logic signed [CoordW-1:0] n_x, n_y, n_z;
    logic signed [CoordW-1:0] ca_x, ca_y, ca_z;
    logic signed [CoordW-1:0] co_x, co_y, co_z;
    logic signed [CoordW-1:0] cb_x, cb_y, cb_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] dev_x, dev_y, dev_z;
    logic [CoordW-1:0] deviation;
    logic valid_res;
  } out_item_t;

  typedef struct packed {
    logic signed [DevW-1:0] dx, dy, dz;
    logic ok;
  } dev_vec_t;
endpackage

>>> hdl/icd_stream_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
interface icd_stream_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/ideal_cbeta_deviation.sv
// Ideal beta-carbon deviation: one residue item in, one residual item out.
// Depends on icd_pkg, icd_stream_if, icd_geom, icd_len and assert_macros.svh.
// The block takes one item per cycle while the output is not stalled; the path is four geometry stages and
// a 28-stage length pipe with its squaring, square-root and output registers.
// The whole pipe advances while the result register is empty or taken, so a stall loses nothing.
module ideal_cbeta_deviation (
  input  logic clk,
  input  logic rst_n,
  icd_stream_if.sink in_ch,
  icd_stream_if.source out_ch
);
  import icd_pkg::*;
  `include "assert_macros.svh"

  logic en, gv, lv;
  dev_vec_t gd;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  icd_geom u_geom (.clk(clk), .rst_n(rst_n), .en(en), .in_v(in_ch.valid && en),
    .in_d(in_ch.data), .out_v(gv), .out_d(gd));
  icd_len u_len (.clk(clk), .rst_n(rst_n), .en(en), .in_v(gv), .in_d(gd),
    .out_v(lv), .out_d(out_ch.data));

  assign out_ch.valid = lv;

  `ICD_ASSERT_NEXT(a_stall, out_ch.valid && !out_ch.ready, out_ch.valid,
    "result item dropped under stall")
  `ICD_ASSERT_IMP(a_rdy, out_ch.valid && !out_ch.ready, !in_ch.ready,
    "input taken while pipe stalled")
endmodule

>>> hdl/icd_geom.sv
// Geometry stages: differences, cross product, residual sums and rounding.
// Depends on icd_pkg and assert_macros.svh.
module icd_geom (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  icd_pkg::in_item_t in_d,
  output logic out_v,
  output icd_pkg::dev_vec_t out_d
);
  import icd_pkg::*;
  `include "assert_macros.svh"

  logic [3:0] v_r;
  logic signed [DiffW-1:0] n_r [3], c_r [3], d_r [3];
  logic signed [DiffW-1:0] n2_r [3], c2_r [3], d2_r [3];
  logic signed [CrossW-1:0] cr_r [3];
  logic signed [SumW-1:0] s_r [3];
  logic degen_r, degen2_r;
  dev_vec_t dv_r;
  logic signed [CoordW-1:0] a [3], b [3], cc [3], e [3];
  logic signed [CrossW-1:0] cr_nxt [3];
  logic signed [XrW-1:0] xr [3];
  logic signed [SumW-1:0] s_nxt [3];
  logic signed [SumW-1:0] r [3];

  assign a = '{in_d.n_x, in_d.n_y, in_d.n_z};
  assign b = '{in_d.ca_x, in_d.ca_y, in_d.ca_z};
  assign cc = '{in_d.co_x, in_d.co_y, in_d.co_z};
  assign e = '{in_d.cb_x, in_d.cb_y, in_d.cb_z};

  always_comb begin
    cr_nxt[0] = CrossW'(c_r[1] * n_r[2]) - CrossW'(c_r[2] * n_r[1]);
    cr_nxt[1] = CrossW'(c_r[2] * n_r[0]) - CrossW'(c_r[0] * n_r[2]);
    cr_nxt[2] = CrossW'(c_r[0] * n_r[1]) - CrossW'(c_r[1] * n_r[0]);
    for (int i = 0; i < 3; i++) begin
      xr[i] = XrW'((cr_r[i] + CrossW'(512)) >>> 10);
      s_nxt[i] = (SumW'(d2_r[i]) <<< 20) + SumW'(CoefCross * xr[i])
               - SumW'(CoefN * n2_r[i]) + SumW'(CoefC * c2_r[i]);
      r[i] = (s_r[i] + SumW'(64'sd524288)) >>> 20;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= DiffW'(a[i]) - DiffW'(b[i]);
        c_r[i] <= DiffW'(cc[i]) - DiffW'(b[i]);
        d_r[i] <= DiffW'(e[i]) - DiffW'(b[i]);
        cr_r[i] <= cr_nxt[i];
        n2_r[i] <= n_r[i];
        c2_r[i] <= c_r[i];
        d2_r[i] <= d_r[i];
        s_r[i] <= s_nxt[i];
      end
      degen_r <= (n_r[0] == 0 && n_r[1] == 0 && n_r[2] == 0) ||
                 (c_r[0] == 0 && c_r[1] == 0 && c_r[2] == 0);
      degen2_r <= degen_r || (cr_r[0] == 0 && cr_r[1] == 0 && cr_r[2] == 0);
      dv_r.ok <= !degen2_r;
      dv_r.dx <= degen2_r ? '0 : DevW'(r[0]);
      dv_r.dy <= degen2_r ? '0 : DevW'(r[1]);
      dv_r.dz <= degen2_r ? '0 : DevW'(r[2]);
    end
  end

  assign out_v = v_r[3];
  assign out_d = dv_r;

  `ICD_ASSERT_NEXT(a_hold, !en, $stable(v_r), "geometry pipe moved while stalled")
  `ICD_ASSERT_IMP(a_zero, out_v && !out_d.ok, out_d.dx == 0 && out_d.dz == 0,
    "degenerate item has nonzero residual")
endmodule

>>> hdl/icd_len.sv
// Length stages: squared sum and pipelined integer square root, then saturation.
// Depends on icd_pkg and assert_macros.svh.
module icd_len (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  icd_pkg::dev_vec_t in_d,
  output logic out_v,
  output icd_pkg::out_item_t out_d
);
  import icd_pkg::*;
  `include "assert_macros.svh"

  localparam int Depth = SqrtSteps + 3;

  logic [Depth-1:0] v_r;
  dev_vec_t q_r [Depth-1];
  logic big_r;
  logic [SqW-1:0] sq_r;
  logic [SqW-1:0] rem_r [SqrtSteps+1];
  logic [LenW-1:0] root_r [SqrtSteps+1];
  logic [SqrtSteps:0] bigp_r;
  out_item_t o_r;
  logic [DevW-1:0] m [3];
  logic [SqW-1:0] trial [SqrtSteps];

  function automatic logic signed [CoordW-1:0] sat(input logic signed [DevW-1:0] v);
    if (v > DevW'(8388607)) return 24'sh7FFFFF;
    if (v < -DevW'(8388608)) return 24'sh800000;
    return v[CoordW-1:0];
  endfunction

  always_comb begin
    m[0] = in_d.dx < 0 ? DevW'(-in_d.dx) : DevW'(in_d.dx);
    m[1] = in_d.dy < 0 ? DevW'(-in_d.dy) : DevW'(in_d.dy);
    m[2] = in_d.dz < 0 ? DevW'(-in_d.dz) : DevW'(in_d.dz);
    for (int k = 0; k < SqrtSteps; k++) begin
      trial[k] = SqW'({root_r[k], 2'b01}) << (2 * (SqrtSteps - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Depth-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0] <= in_d;
      for (int k = 1; k < Depth - 1; k++) q_r[k] <= q_r[k-1];
      big_r <= m[0] >= DevW'(1 << 24) || m[1] >= DevW'(1 << 24) || m[2] >= DevW'(1 << 24);
      sq_r <= SqW'(m[0][23:0] * m[0][23:0]) + SqW'(m[1][23:0] * m[1][23:0])
            + SqW'(m[2][23:0] * m[2][23:0]);
      rem_r[0] <= sq_r;
      root_r[0] <= '0;
      bigp_r[0] <= big_r;
      for (int k = 0; k < SqrtSteps; k++) begin
        bigp_r[k+1] <= bigp_r[k];
        if (rem_r[k] >= trial[k]) begin
          rem_r[k+1] <= rem_r[k] - trial[k];
          root_r[k+1] <= {root_r[k][LenW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem_r[k];
          root_r[k+1] <= {root_r[k][LenW-2:0], 1'b0};
        end
      end
      o_r.dev_x <= sat(q_r[Depth-2].dx);
      o_r.dev_y <= sat(q_r[Depth-2].dy);
      o_r.dev_z <= sat(q_r[Depth-2].dz);
      o_r.valid_res <= q_r[Depth-2].ok;
      o_r.deviation <= (bigp_r[SqrtSteps] || root_r[SqrtSteps][LenW-1]) ? '1
                     : root_r[SqrtSteps][CoordW-1:0];
    end
  end

  assign out_v = v_r[Depth-1];
  assign out_d = o_r;

  `ICD_ASSERT_NEXT(a_hold, !en, $stable(v_r), "length pipe moved while stalled")
  `ICD_ASSERT_IMP(a_inv, out_v && !out_d.valid_res, out_d.deviation == 0,
    "degenerate item has nonzero length")
endmodule
